FILE: rtl/core/supe_pkg.sv
// ----------------------------------------------------------------------------
// supe_pkg
// Shared types, constants and helpers of the 3-SAT unit propagation engine.
// ----------------------------------------------------------------------------
package supe_pkg;

    // Sizes of the clause table and the variable store
    localparam int NUM_VARS    = 1024;
    localparam int NUM_CLAUSES = 4096;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int CI_W     = 12;
    localparam int VAR_FW   = 10;
    localparam int CFG_W    = 13;
    localparam int VAL_W    = 2;
    localparam int LITS     = 3;
    localparam int LIT_BITS = VAR_FW + 1;
    localparam int LITS_W   = LITS * LIT_BITS;

    // Derived address and counter widths
    localparam int VAR_AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CL_AW  = (NUM_CLAUSES > 1) ? $clog2(NUM_CLAUSES) : 1;
    localparam int CNT_W  = $clog2(NUM_CLAUSES + 1);
    localparam int CLR_N  = (NUM_CLAUSES > NUM_VARS) ? NUM_CLAUSES : NUM_VARS;
    localparam int CLR_AW = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    // Three-valued variable codes
    localparam logic [VAL_W-1:0] VAL_FREE  = 2'd0;
    localparam logic [VAL_W-1:0] VAL_FALSE = 2'd1;
    localparam logic [VAL_W-1:0] VAL_TRUE  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ASSIGN = 2'd1,
        OP_PROP   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDV,
        S_PSCAN,
        S_CWAIT,
        S_V0,
        S_V1,
        S_V2,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t               opcode;
        logic [CI_W-1:0]   clause_index;
        logic [VAR_FW-1:0] lit_var_0;
        logic [VAR_FW-1:0] lit_var_1;
        logic [VAR_FW-1:0] lit_var_2;
        logic              lit_pos_0;
        logic              lit_pos_1;
        logic              lit_pos_2;
        logic [VAR_FW-1:0] variable;
        logic              truth;
    } item_t;

    // Clause entry: active mark over three literals (lit 0 lowest)
    typedef struct packed {
        logic              active;
        logic [LITS_W-1:0] lits;
    } clause_word_t;

    typedef struct packed {
        logic         we;
        logic [CL_AW-1:0] waddr;
        clause_word_t wdata;
        logic [CL_AW-1:0] raddr;
    } clause_req_t;

    typedef struct packed {
        logic              we;
        logic [VAR_AW-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [VAR_AW-1:0] raddr;
    } var_req_t;

    // Map a variable number onto a store slot
    function automatic logic [VAR_AW-1:0] var_slot(input logic [VAR_FW-1:0] v);
        return VAR_AW'(32'(v) % NUM_VARS);
    endfunction

endpackage

FILE: rtl/core/sat_unit_propagation_engine.sv
// ----------------------------------------------------------------------------
// sat_unit_propagation_engine
// 3-SAT unit propagation engine with clause table and variable store.
// ----------------------------------------------------------------------------
// After reset the block sweeps its clause table and variable store, one
// entry a cycle, across the larger of the two stores; s_tready stays low
// meanwhile, configuration writes are taken at once. Every item gives
// exactly one result, and no new item is taken until that result has been
// handed to the output register. Propagate visits each clause in the
// scanned range per pass and repeats passes until one fixes nothing; a
// conflict cuts the last pass short. An active clause costs more than an
// inactive one, since the single read port of the variable store serves
// the three literals of a clause one after another.
// The result waits in an output register until m_tready takes it.
// ----------------------------------------------------------------------------
module sat_unit_propagation_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: clause_index[11:0], lit_var_0[21:12], lit_var_1[31:22],
    //        lit_var_2[41:32], lit_pos_0[42], lit_pos_1[43], lit_pos_2[44],
    //        variable[54:45], truth[55]
    input  logic [55:0] s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[0], var_value[2:1], zero[7:3]
    output logic [7:0]  m_tdata,
    // Configuration write: clause_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);

    supe_pkg::item_t        item;
    supe_pkg::clause_req_t  clause_req;
    supe_pkg::clause_word_t clause_rdata;
    supe_pkg::var_req_t     var_req;
    logic [supe_pkg::VAL_W-1:0] var_rdata;

    logic                        res_valid;
    logic                        res_ready;
    logic                        res_status;
    logic [supe_pkg::VAL_W-1:0]  res_value;
    logic [supe_pkg::CFG_W-1:0]  clause_count_reg;
    logic                        m_tvalid_reg;
    logic [7:0]                  m_tdata_reg;

    // Unpack the input item
    assign item.opcode       = supe_pkg::op_t'(s_tuser);
    assign item.clause_index = s_tdata[11:0];
    assign item.lit_var_0    = s_tdata[21:12];
    assign item.lit_var_1    = s_tdata[31:22];
    assign item.lit_var_2    = s_tdata[41:32];
    assign item.lit_pos_0    = s_tdata[42];
    assign item.lit_pos_1    = s_tdata[43];
    assign item.lit_pos_2    = s_tdata[44];
    assign item.variable     = s_tdata[54:45];
    assign item.truth        = s_tdata[55];

    // Hold the clause count
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clause_count_reg <= '0;
        end else if (cfg_valid) begin
            clause_count_reg <= cfg_data;
        end
    end

    supe_scan_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .item         (item),
        .clause_count (clause_count_reg),
        .clause_req   (clause_req),
        .clause_rdata (clause_rdata),
        .var_req      (var_req),
        .var_rdata    (var_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_status   (res_status),
        .res_value    (res_value)
    );

    supe_clause_mem u_clause_mem (
        .aclk  (aclk),
        .req   (clause_req),
        .rdata (clause_rdata)
    );

    supe_var_mem u_var_mem (
        .aclk  (aclk),
        .req   (var_req),
        .rdata (var_rdata)
    );

    // Output register: load a result when empty or being taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {5'b0, res_value, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/supe_clause_mem.sv
// ----------------------------------------------------------------------------
// supe_clause_mem
// Clause table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module supe_clause_mem (
    input  logic                  aclk,
    input  supe_pkg::clause_req_t req,
    output supe_pkg::clause_word_t rdata
);

    supe_pkg::clause_word_t mem [supe_pkg::NUM_CLAUSES];

    // Write and read the table
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

FILE: rtl/core/supe_var_mem.sv
// ----------------------------------------------------------------------------
// supe_var_mem
// Variable store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module supe_var_mem (
    input  logic                           aclk,
    input  supe_pkg::var_req_t             req,
    output logic [supe_pkg::VAL_W-1:0]     rdata
);

    logic [supe_pkg::VAL_W-1:0] mem [supe_pkg::NUM_VARS];

    // Write and read the store
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

FILE: rtl/core/supe_scan_ctrl.sv
// ----------------------------------------------------------------------------
// supe_scan_ctrl
// Sequencer: clears both stores after reset, runs the four operations and
// walks the clause table for propagation, one variable read a cycle.
// ----------------------------------------------------------------------------
module supe_scan_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  supe_pkg::item_t                   item,
    input  logic [supe_pkg::CFG_W-1:0]        clause_count,
    output supe_pkg::clause_req_t             clause_req,
    input  supe_pkg::clause_word_t            clause_rdata,
    output supe_pkg::var_req_t                var_req,
    input  logic [supe_pkg::VAL_W-1:0]        var_rdata,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              res_status,
    output logic [supe_pkg::VAL_W-1:0]        res_value
);

    supe_pkg::state_t state_reg, state_next;
    supe_pkg::op_t    op_reg, op_next;

    logic [supe_pkg::CLR_AW-1:0] clr_reg, clr_next;
    logic [supe_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [supe_pkg::CNT_W-1:0]  limit_reg, limit_next;
    logic                        changed_reg, changed_next;
    supe_pkg::clause_word_t      word_reg, word_next;
    logic [supe_pkg::VAL_W-1:0]  val0_reg, val0_next;
    logic [supe_pkg::VAL_W-1:0]  val1_reg, val1_next;
    logic                        res_status_reg, res_status_next;
    logic [supe_pkg::VAL_W-1:0]  res_value_reg, res_value_next;

    logic                          eval_sat;
    logic [1:0]                    eval_free_cnt;
    logic [supe_pkg::VAR_AW-1:0]   eval_free_var;
    logic                          eval_free_pos;
    logic                          scan_end;
    logic                          clr_last;
    logic [supe_pkg::VAL_W-1:0]    lit_val [supe_pkg::LITS];

    assign scan_end = (idx_reg == limit_reg);
    assign clr_last = (clr_reg == supe_pkg::CLR_AW'(supe_pkg::CLR_N - 1));

    // Judge the clause held in word_reg against its three variable values
    assign lit_val[0] = val0_reg;
    assign lit_val[1] = val1_reg;
    assign lit_val[2] = var_rdata;

    always_comb begin
        eval_sat      = 1'b0;
        eval_free_cnt = 2'd0;
        eval_free_var = '0;
        eval_free_pos = 1'b0;
        for (int k = 0; k < supe_pkg::LITS; k++) begin
            if (lit_val[k] == supe_pkg::VAL_FREE) begin
                eval_free_cnt = eval_free_cnt + 2'd1;
                eval_free_var = supe_pkg::var_slot(
                    word_reg.lits[supe_pkg::LIT_BITS*k +: supe_pkg::VAR_FW]);
                eval_free_pos = word_reg.lits[supe_pkg::LIT_BITS*k + supe_pkg::VAR_FW];
            end else if ((word_reg.lits[supe_pkg::LIT_BITS*k + supe_pkg::VAR_FW] &&
                          lit_val[k] == supe_pkg::VAL_TRUE) ||
                         (!word_reg.lits[supe_pkg::LIT_BITS*k + supe_pkg::VAR_FW] &&
                          lit_val[k] == supe_pkg::VAL_FALSE)) begin
                eval_sat = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            supe_pkg::S_CLEAR: begin
                if (clr_last) state_next = supe_pkg::S_IDLE;
            end
            supe_pkg::S_IDLE: begin
                if (in_valid) begin
                    case (item.opcode)
                        supe_pkg::OP_PROP: state_next = supe_pkg::S_PSCAN;
                        supe_pkg::OP_READ: state_next = supe_pkg::S_RDV;
                        default:           state_next = supe_pkg::S_RESP;
                    endcase
                end
            end
            supe_pkg::S_RDV: state_next = supe_pkg::S_RESP;
            supe_pkg::S_PSCAN: begin
                if (!scan_end) begin
                    state_next = supe_pkg::S_CWAIT;
                end else if (!changed_reg) begin
                    state_next = supe_pkg::S_RESP;
                end
            end
            supe_pkg::S_CWAIT: begin
                state_next = clause_rdata.active ? supe_pkg::S_V0 : supe_pkg::S_PSCAN;
            end
            supe_pkg::S_V0: state_next = supe_pkg::S_V1;
            supe_pkg::S_V1: state_next = supe_pkg::S_V2;
            supe_pkg::S_V2: begin
                if (!eval_sat && eval_free_cnt == 2'd0) begin
                    state_next = supe_pkg::S_RESP;
                end else begin
                    state_next = supe_pkg::S_PSCAN;
                end
            end
            supe_pkg::S_RESP: begin
                if (res_ready) state_next = supe_pkg::S_IDLE;
            end
            default: state_next = supe_pkg::S_CLEAR;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        clause_req      = '0;
        var_req         = '0;
        op_next         = op_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        limit_next      = limit_reg;
        changed_next    = changed_reg;
        word_next       = word_reg;
        val0_next       = val0_reg;
        val1_next       = val1_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        case (state_reg)
            supe_pkg::S_CLEAR: begin
                // Sweep both stores back to inactive and unassigned
                clause_req.we    = (32'(clr_reg) < supe_pkg::NUM_CLAUSES);
                clause_req.waddr = supe_pkg::CL_AW'(clr_reg);
                var_req.we       = (32'(clr_reg) < supe_pkg::NUM_VARS);
                var_req.waddr    = supe_pkg::VAR_AW'(clr_reg);
                var_req.wdata    = supe_pkg::VAL_FREE;
                clr_next         = clr_reg + 1'b1;
            end
            supe_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next         = item.opcode;
                    res_status_next = 1'b0;
                    res_value_next  = supe_pkg::VAL_FREE;
                    case (item.opcode)
                        supe_pkg::OP_LOAD: begin
                            clause_req.we    = (32'(item.clause_index) <
                                                supe_pkg::NUM_CLAUSES);
                            clause_req.waddr = supe_pkg::CL_AW'(item.clause_index);
                            clause_req.wdata.active = 1'b1;
                            clause_req.wdata.lits   = {item.lit_pos_2, item.lit_var_2,
                                                       item.lit_pos_1, item.lit_var_1,
                                                       item.lit_pos_0, item.lit_var_0};
                        end
                        supe_pkg::OP_ASSIGN: begin
                            var_req.we    = 1'b1;
                            var_req.waddr = supe_pkg::var_slot(item.variable);
                            var_req.wdata = item.truth ? supe_pkg::VAL_TRUE
                                                       : supe_pkg::VAL_FALSE;
                        end
                        supe_pkg::OP_PROP: begin
                            limit_next   = (32'(clause_count) > supe_pkg::NUM_CLAUSES) ?
                                           supe_pkg::CNT_W'(supe_pkg::NUM_CLAUSES) :
                                           supe_pkg::CNT_W'(clause_count);
                            idx_next     = '0;
                            changed_next = 1'b0;
                        end
                        supe_pkg::OP_READ: begin
                            var_req.raddr = supe_pkg::var_slot(item.variable);
                        end
                        default: ;
                    endcase
                end
            end
            supe_pkg::S_RDV: begin
                res_value_next = var_rdata;
            end
            supe_pkg::S_PSCAN: begin
                // Fetch the next clause, or restart the pass after a fix
                if (!scan_end) begin
                    clause_req.raddr = supe_pkg::CL_AW'(idx_reg);
                end else if (changed_reg) begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                end
            end
            supe_pkg::S_CWAIT: begin
                if (clause_rdata.active) begin
                    word_next     = clause_rdata;
                    var_req.raddr = supe_pkg::var_slot(
                        clause_rdata.lits[supe_pkg::VAR_FW-1:0]);
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            supe_pkg::S_V0: begin
                val0_next     = var_rdata;
                var_req.raddr = supe_pkg::var_slot(
                    word_reg.lits[supe_pkg::LIT_BITS +: supe_pkg::VAR_FW]);
            end
            supe_pkg::S_V1: begin
                val1_next     = var_rdata;
                var_req.raddr = supe_pkg::var_slot(
                    word_reg.lits[2*supe_pkg::LIT_BITS +: supe_pkg::VAR_FW]);
            end
            supe_pkg::S_V2: begin
                if (eval_sat) begin
                    // Drop a satisfied clause from later passes
                    clause_req.we           = 1'b1;
                    clause_req.waddr        = supe_pkg::CL_AW'(idx_reg);
                    clause_req.wdata.active = 1'b0;
                    clause_req.wdata.lits   = word_reg.lits;
                    idx_next                = idx_reg + 1'b1;
                end else if (eval_free_cnt == 2'd0) begin
                    res_status_next = 1'b1;
                end else begin
                    if (eval_free_cnt == 2'd1) begin
                        var_req.we    = 1'b1;
                        var_req.waddr = eval_free_var;
                        var_req.wdata = eval_free_pos ? supe_pkg::VAL_TRUE
                                                      : supe_pkg::VAL_FALSE;
                        changed_next  = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            supe_pkg::S_RESP: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign res_status = res_status_reg;
    assign res_value  = res_value_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= supe_pkg::S_CLEAR;
            clr_reg     <= '0;
            changed_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            changed_reg <= changed_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        limit_reg      <= limit_next;
        word_reg       <= word_next;
        val0_reg       <= val0_next;
        val1_reg       <= val1_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
    end

    // Only propagate may report a conflict
    a_conflict_prop : assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_status) |-> (op_reg == supe_pkg::OP_PROP))
        else $error("conflict reported for an operation other than propagate");

    // The scan index never runs past the clamped clause count
    a_idx_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == supe_pkg::S_PSCAN) |-> (idx_reg <= limit_reg))
        else $error("scan index beyond clause count");

    // A clause either fixes a variable or is deactivated, never both
    a_fix_xor_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == supe_pkg::S_V2 && var_req.we) |-> !clause_req.we)
        else $error("fix and deactivation in the same clause");

    // A fix forces another pass
    a_fix_changed : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == supe_pkg::S_V2 && var_req.we) |=> changed_reg)
        else $error("fix did not mark the pass as changed");

    // Every accepted item leaves the idle state
    a_accept_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != supe_pkg::S_IDLE))
        else $error("item accepted without starting work");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3-SAT unit propagation engine. A directed
// sequence covers the field extremes, a clause with a repeated variable, a
// conflict after earlier fixes and the clamped clause count. Random phases
// then run clause sets with assigns, propagates and reads over fresh
// variables, mixed with noise items, at several clause counts. Every result
// is checked against a local model of the clause table and variable store.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct {
        logic       status;
        logic [1:0] var_value;
    } outcome_t;

    // Clock, reset and block ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = '0;

    // Local copy of the block state
    bit [32:0]  clause_words [supe_pkg::NUM_CLAUSES];
    bit         clause_live  [supe_pkg::NUM_CLAUSES];
    bit [1:0]   var_store    [supe_pkg::NUM_VARS];
    bit [12:0]  scan_count;

    // Items waiting to be sent and results waiting to arrive
    supe_pkg::item_t pending_ops[$];
    outcome_t        pending_outcomes[$];
    supe_pkg::item_t cur_op;
    bit         in_taken   = 1'b0;
    bit         steady     = 1'b0;
    int         queued;
    int         window_base = 16;

    int         cycle_count = 0;
    int         err_count   = 0;
    int         n_checked   = 0;
    int         n_load      = 0;
    int         n_assign    = 0;
    int         n_prop      = 0;
    int         n_conflict  = 0;
    int         n_read      = 0;
    int         cfg_writes  = 0;

    sat_unit_propagation_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scan the live clauses until a whole pass fixes nothing; 1 on conflict
    function automatic bit run_propagation();
        int        lim;
        bit        changed;
        bit        sat;
        int        nfree;
        int        fvar;
        bit        fpos;
        bit [10:0] lit;
        int        v;
        bit [1:0]  val;
        lim = (scan_count > supe_pkg::NUM_CLAUSES) ? supe_pkg::NUM_CLAUSES
                                                   : int'(scan_count);
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int c = 0; c < lim; c++) begin
                if (!clause_live[c])
                    continue;
                sat   = 1'b0;
                nfree = 0;
                fvar  = 0;
                fpos  = 1'b0;
                for (int k = 0; k < supe_pkg::LITS; k++) begin
                    lit = clause_words[c][k*supe_pkg::LIT_BITS +: supe_pkg::LIT_BITS];
                    v   = int'(lit[supe_pkg::VAR_FW-1:0]) % supe_pkg::NUM_VARS;
                    val = var_store[v];
                    if (val == supe_pkg::VAL_FREE) begin
                        nfree++;
                        fvar = v;
                        fpos = lit[supe_pkg::VAR_FW];
                    end else if ((lit[supe_pkg::VAR_FW] && val == supe_pkg::VAL_TRUE) ||
                                 (!lit[supe_pkg::VAR_FW] && val == supe_pkg::VAL_FALSE))
                    begin
                        sat = 1'b1;
                    end
                end
                if (sat) begin
                    clause_live[c] = 1'b0;
                    continue;
                end
                if (nfree == 0)
                    return 1'b1;
                if (nfree == 1) begin
                    var_store[fvar] = fpos ? supe_pkg::VAL_TRUE : supe_pkg::VAL_FALSE;
                    changed = 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted item to the local state and give its result
    function automatic outcome_t apply_item(input supe_pkg::item_t it);
        outcome_t res;
        res.status    = 1'b0;
        res.var_value = supe_pkg::VAL_FREE;
        case (it.opcode)
            supe_pkg::OP_LOAD: begin
                clause_words[it.clause_index] = {it.lit_pos_2, it.lit_var_2,
                                                 it.lit_pos_1, it.lit_var_1,
                                                 it.lit_pos_0, it.lit_var_0};
                clause_live[it.clause_index] = 1'b1;
                n_load++;
            end
            supe_pkg::OP_ASSIGN: begin
                var_store[int'(it.variable) % supe_pkg::NUM_VARS] =
                    it.truth ? supe_pkg::VAL_TRUE : supe_pkg::VAL_FALSE;
                n_assign++;
            end
            supe_pkg::OP_PROP: begin
                res.status = run_propagation();
                n_prop++;
                if (res.status)
                    n_conflict++;
            end
            default: begin
                res.var_value = var_store[int'(it.variable) % supe_pkg::NUM_VARS];
                n_read++;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Item builders: unused fields carry random bits
    function automatic supe_pkg::item_t random_item();
        bit [57:0] raw;
        raw = 58'({$urandom, $urandom});
        return supe_pkg::item_t'(raw);
    endfunction

    function automatic void push_item(input supe_pkg::item_t it);
        pending_ops.push_back(it);
        queued++;
    endfunction

    function automatic void queue_load(input int idx, input int v0, input bit p0,
                                       input int v1, input bit p1,
                                       input int v2, input bit p2);
        supe_pkg::item_t it;
        it = random_item();
        it.opcode       = supe_pkg::OP_LOAD;
        it.clause_index = supe_pkg::CI_W'(idx);
        it.lit_var_0    = supe_pkg::VAR_FW'(v0);
        it.lit_var_1    = supe_pkg::VAR_FW'(v1);
        it.lit_var_2    = supe_pkg::VAR_FW'(v2);
        it.lit_pos_0    = p0;
        it.lit_pos_1    = p1;
        it.lit_pos_2    = p2;
        push_item(it);
    endfunction

    function automatic void queue_assign(input int v, input bit t);
        supe_pkg::item_t it;
        it = random_item();
        it.opcode   = supe_pkg::OP_ASSIGN;
        it.variable = supe_pkg::VAR_FW'(v);
        it.truth    = t;
        push_item(it);
    endfunction

    function automatic void queue_prop();
        supe_pkg::item_t it;
        it = random_item();
        it.opcode = supe_pkg::OP_PROP;
        push_item(it);
    endfunction

    function automatic void queue_read(input int v);
        supe_pkg::item_t it;
        it = random_item();
        it.opcode   = supe_pkg::OP_READ;
        it.variable = supe_pkg::VAR_FW'(v);
        push_item(it);
    endfunction

    // One small problem over a window of fresh variables: clauses, some
    // decisions, propagate, then read the window back
    function automatic void queue_episode();
        int lim;
        int nclauses;
        int first;
        lim      = (scan_count > supe_pkg::NUM_CLAUSES) ? supe_pkg::NUM_CLAUSES
                                                        : int'(scan_count);
        nclauses = $urandom_range(2, 5);
        first    = 0;
        if (lim > nclauses && $urandom_range(0, 99) < 30)
            first = $urandom_range(0, lim - nclauses);
        for (int j = 0; j < nclauses; j++)
            queue_load(first + j,
                       window_base + $urandom_range(0, 4), 1'($urandom_range(0, 1)),
                       window_base + $urandom_range(0, 4), 1'($urandom_range(0, 1)),
                       window_base + $urandom_range(0, 4), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 2))
            queue_assign(window_base + $urandom_range(0, 4), 1'($urandom_range(0, 1)));
        queue_prop();
        repeat ($urandom_range(2, 4))
            queue_read(window_base + $urandom_range(0, 4));
        if ($urandom_range(0, 99) < 30) begin
            queue_assign(window_base + $urandom_range(0, 4), 1'($urandom_range(0, 1)));
            queue_prop();
            queue_read(window_base + $urandom_range(0, 4));
            queue_read(window_base + $urandom_range(0, 4));
        end
        window_base = (window_base + 5) % supe_pkg::NUM_VARS;
    endfunction

    // Hold until nothing is left to send or to receive
    task automatic drain_block();
        while (pending_ops.size() != 0 || s_tvalid || pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_clause_count(input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= 13'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        scan_count = 13'(value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int n_items, input bit no_gaps);
        set_clause_count(count);
        steady = no_gaps;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(0, 99) < 20)
                push_item(random_item());
            else
                queue_episode();
        end
        drain_block();
        steady = 1'b0;
    endtask

    // Driver: present the next item at the falling edge, with random gaps
    always @(negedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid && !in_taken;
        in_taken   = 1'b0;
        if (!next_valid && aresetn && pending_ops.size() != 0 &&
            (steady || $urandom_range(0, 99) >= 33)) begin
            cur_op = pending_ops.pop_front();
            s_tdata <= {cur_op.truth, cur_op.variable,
                        cur_op.lit_pos_2, cur_op.lit_pos_1, cur_op.lit_pos_0,
                        cur_op.lit_var_2, cur_op.lit_var_1, cur_op.lit_var_0,
                        cur_op.clause_index};
            s_tuser <= cur_op.opcode;
            next_valid = 1'b1;
        end
        s_tvalid <= next_valid;
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // Monitor: check results, then predict for an item taken at this edge
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing expected", m_tdata));
                end else begin
                    want = pending_outcomes.pop_front();
                    n_checked++;
                    if (m_tdata[0] !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  m_tdata[0], want.status));
                    if (m_tdata[2:1] !== want.var_value)
                        report_mismatch($sformatf("var_value %0d, expected %0d",
                                                  m_tdata[2:1], want.var_value));
                end
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                pending_outcomes.push_back(apply_item(cur_op));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, whole table scanned through an over-range count
        set_clause_count(8191);
        queue_read(0);
        queue_read(1023);
        queue_prop();
        // repeated variable in the last table entry
        queue_load(4095, 1023, 1'b1, 0, 1'b0, 1023, 1'b1);
        queue_load(0, 5, 1'b1, 6, 1'b1, 7, 1'b1);
        queue_assign(0, 1'b1);
        queue_prop();
        // unit clause fixes variable 7
        queue_assign(5, 1'b0);
        queue_assign(6, 1'b0);
        queue_prop();
        queue_read(7);
        // two free literals on one variable: no fix
        queue_load(1, 8, 1'b0, 8, 1'b0, 9, 1'b0);
        queue_assign(9, 1'b1);
        queue_prop();
        // all literals of the last entry false
        queue_assign(1023, 1'b0);
        queue_prop();
        queue_read(1023);
        // fix made ahead of the conflict stays
        queue_load(2, 10, 1'b1, 11, 1'b1, 12, 1'b1);
        queue_assign(10, 1'b0);
        queue_assign(11, 1'b0);
        queue_prop();
        queue_read(12);
        // replace the conflicting entry with a satisfied one
        queue_load(4095, 1023, 1'b0, 13, 1'b1, 13, 1'b1);
        queue_prop();
        drain_block();

        // Random phases; the drain between them also holds the sender back
        run_phase(0, 150, 1'b0);
        run_phase(12, 300, 1'b1);
        run_phase(48, 350, 1'b0);
        run_phase(4096, 20, 1'b0);
        run_phase(1, 150, 1'b0);
        run_phase(30, 380, 1'b0);
        repeat (20) @(posedge aclk);

        $display("Checked %0d results: %0d loads, %0d assigns, %0d reads, %0d propagates",
                 n_checked, n_load, n_assign, n_read, n_prop);
        $display("%0d propagates hit a conflict; clause count written %0d times",
                 n_conflict, cfg_writes);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/supe_pkg.sv
rtl/core/supe_clause_mem.sv
rtl/core/supe_var_mem.sv
rtl/core/supe_scan_ctrl.sv
rtl/core/sat_unit_propagation_engine.sv
tb/testbench.sv
